// ===== hdl/ascii_number_parser_core_defines.svh =====
// ---------------------------------------------------------------------------
// ascii number parser assertion macros
// shared property forms for the parser checks
// ---------------------------------------------------------------------------
`ifndef ASCII_NUMBER_PARSER_CORE_DEFINES_SVH
`define ASCII_NUMBER_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define ANP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("anp assertion failed");

// next-cycle implication
`define ANP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("anp assertion failed");

`endif

// ===== hdl/anp_pkg.sv =====
// ---------------------------------------------------------------------------
// anp_pkg
// types and character constants of the ascii number parser
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package anp_pkg;

  localparam int unsigned CharWidth  = 8;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned DigitWidth = 4;
  localparam int unsigned CountWidth = 4;

  localparam logic [CharWidth-1:0] CharSpace  = 8'h20;
  localparam logic [CharWidth-1:0] CharMinus  = 8'h2D;
  localparam logic [CharWidth-1:0] CharZero   = 8'h30;
  localparam logic [CharWidth-1:0] CharNine   = 8'h39;
  localparam logic [CharWidth-1:0] CharUpperA = 8'h41;
  localparam logic [CharWidth-1:0] CharUpperF = 8'h46;
  localparam logic [CharWidth-1:0] CharUpperX = 8'h58;
  localparam logic [CharWidth-1:0] CharLowerA = 8'h61;
  localparam logic [CharWidth-1:0] CharLowerF = 8'h66;
  localparam logic [CharWidth-1:0] CharLowerX = 8'h78;

  localparam logic [CountWidth-1:0] DecMaxDigits = 4'd10;
  localparam logic [CountWidth-1:0] HexMaxDigits = 4'd8;

  typedef struct packed {
    logic                  is_space;
    logic                  is_minus;
    logic                  is_zero;
    logic                  is_x;
    logic                  dec_ok;
    logic                  hex_ok;
    logic [DigitWidth-1:0] digit;
  } char_class_t;

  typedef struct packed {
    logic [ValueWidth-1:0] acc;
    logic                  neg;
    logic                  err;
  } parse_result_t;

endpackage

// ===== hdl/anp_if.sv =====
// ---------------------------------------------------------------------------
// anp stream interfaces
// character and result channels with valid/ready handshake
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface anp_char_if import anp_pkg::*;
  ;
  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] char_code;
  logic                 last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface anp_result_if import anp_pkg::*;
  ;
  logic                  valid;
  logic                  ready;
  logic [ValueWidth-1:0] value;
  logic                  malformed;

  modport source (output valid, value, malformed, input ready);
  modport sink   (input valid, value, malformed, output ready);
endinterface

// ===== hdl/ascii_number_parser_core.sv =====
// ---------------------------------------------------------------------------
// ascii_number_parser_core
// parses a decimal or 0x-prefixed hex ascii string into a 32-bit value
// ---------------------------------------------------------------------------
//  channel    dir  payload               transaction
//  char_i     in   char_code, last_char  one character of the string
//  result_o   out  value, malformed      one result per string
//
//  one character per cycle while no last character waits on a result;
//  accumulator update (shift by four or times ten plus digit) is combinational
//  a result is registered once its last character leaves the input register
//  reset returns the parser to the leading space phase
//  a waiting result stalls only a following last character
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ascii_number_parser_core_defines.svh"

module ascii_number_parser_core import anp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  anp_char_if.sink     char_i,
  anp_result_if.source result_o
);

  logic                 s1_valid_q;
  logic [CharWidth-1:0] s1_char_q;
  logic                 s1_last_q;
  logic                 s1_adv;
  logic                 out_free;
  logic                 out_valid_q;
  parse_result_t        out_res_q;
  parse_result_t        res;
  char_class_t          cls;

  assign out_free     = !out_valid_q || result_o.ready;
  assign s1_adv       = s1_valid_q && (!s1_last_q || out_free);
  assign char_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (char_i.ready) begin
      s1_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.ready && char_i.valid) begin
      s1_char_q <= char_i.char_code;
      s1_last_q <= char_i.last_char;
    end
  end

  anp_char_decode u_decode (
    .char_code_i (s1_char_q),
    .cls_o       (cls)
  );

  anp_parse_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .last_i (s1_last_q),
    .cls_i  (cls),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      out_res_q <= res;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.malformed = out_res_q.err;
  assign result_o.value     = out_res_q.err ? '0 :
                              out_res_q.neg ? ('0 - out_res_q.acc) : out_res_q.acc;

  `ANP_ASSERT_IMP(a_err_zero, out_valid_q && out_res_q.err, result_o.value == '0)
  `ANP_ASSERT_NEXT(a_last_held, s1_valid_q && s1_last_q && !out_free, s1_valid_q && s1_last_q)
  `ANP_ASSERT_IMP(a_out_src, $rose(out_valid_q), $past(s1_valid_q && s1_last_q))

endmodule

// ===== hdl/anp_char_decode.sv =====
// ---------------------------------------------------------------------------
// anp_char_decode
// classifies one character and extracts its decimal or hex digit value
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module anp_char_decode import anp_pkg::*; (
  input  logic [CharWidth-1:0] char_code_i,
  output char_class_t          cls_o
);

  logic is_num;
  logic is_upper;
  logic is_lower;
  logic [CharWidth-1:0] num_off;
  logic [CharWidth-1:0] upper_off;
  logic [CharWidth-1:0] lower_off;

  assign is_num   = (char_code_i >= CharZero) && (char_code_i <= CharNine);
  assign is_upper = (char_code_i >= CharUpperA) && (char_code_i <= CharUpperF);
  assign is_lower = (char_code_i >= CharLowerA) && (char_code_i <= CharLowerF);

  assign num_off   = char_code_i - CharZero;
  assign upper_off = char_code_i - CharUpperA + 8'd10;
  assign lower_off = char_code_i - CharLowerA + 8'd10;

  always_comb begin
    cls_o.is_space = (char_code_i == CharSpace);
    cls_o.is_minus = (char_code_i == CharMinus);
    cls_o.is_zero  = (char_code_i == CharZero);
    cls_o.is_x     = (char_code_i == CharLowerX) || (char_code_i == CharUpperX);
    cls_o.dec_ok   = is_num;
    cls_o.hex_ok   = is_num || is_upper || is_lower;
    if (is_upper) begin
      cls_o.digit = upper_off[DigitWidth-1:0];
    end else if (is_lower) begin
      cls_o.digit = lower_off[DigitWidth-1:0];
    end else begin
      cls_o.digit = num_off[DigitWidth-1:0];
    end
  end

endmodule

// ===== hdl/anp_parse_fsm.sv =====
// ---------------------------------------------------------------------------
// anp_parse_fsm
// parse phase, digit count and accumulator, one character per step
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module anp_parse_fsm import anp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          last_i,
  input  char_class_t   cls_i,
  output parse_result_t res_o
);

  localparam logic [1:0] PhLead = 2'd0;
  localparam logic [1:0] PhZero = 2'd1;
  localparam logic [1:0] PhDec  = 2'd2;
  localparam logic [1:0] PhHex  = 2'd3;

  logic [1:0]            phase_q, phase_d;
  logic [ValueWidth-1:0] acc_q, acc_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic                  neg_q, neg_d;
  logic                  err_q, err_d;

  logic                  take_digit;
  logic                  hex_mode;
  logic [CountWidth-1:0] cnt_inc;
  logic [CountWidth-1:0] limit;
  logic                  digit_ok;
  logic [ValueWidth-1:0] dec_step;
  logic [ValueWidth-1:0] hex_step;
  logic [ValueWidth-1:0] digit_ext;

  assign hex_mode  = (phase_q == PhHex);
  assign cnt_inc   = cnt_q + 4'd1;
  assign digit_ext = {{(ValueWidth-DigitWidth){1'b0}}, cls_i.digit};
  assign dec_step  = (acc_q << 3) + (acc_q << 1) + digit_ext;
  assign hex_step  = {acc_q[ValueWidth-DigitWidth-1:0], cls_i.digit};
  assign limit     = hex_mode ? HexMaxDigits : DecMaxDigits;
  assign digit_ok  = hex_mode ? cls_i.hex_ok : cls_i.dec_ok;

  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    neg_d      = neg_q;
    err_d      = err_q;
    take_digit = 1'b0;
    if (step_i && !err_q) begin
      unique case (phase_q)
        PhZero: begin
          if (cls_i.is_x) begin
            if (last_i) begin
              err_d = 1'b1;
            end else begin
              phase_d = PhHex;
              acc_d   = '0;
              cnt_d   = '0;
            end
          end else begin
            phase_d    = PhDec;
            take_digit = 1'b1;
          end
        end
        PhDec: begin
          take_digit = 1'b1;
        end
        PhHex: begin
          take_digit = 1'b1;
        end
        default: begin
          if (cls_i.is_space) begin
            phase_d = PhLead;
          end else if (cls_i.is_zero) begin
            phase_d    = PhZero;
            take_digit = 1'b1;
          end else if (cls_i.is_minus) begin
            neg_d   = 1'b1;
            phase_d = PhDec;
          end else begin
            phase_d    = PhDec;
            take_digit = 1'b1;
          end
        end
      endcase
      if (take_digit && !cls_i.is_space) begin
        cnt_d = cnt_inc;
        if (cnt_inc > limit) begin
          err_d = 1'b1;
        end else if (!digit_ok) begin
          err_d = 1'b1;
        end else begin
          acc_d = hex_mode ? hex_step : dec_step;
        end
      end
    end
  end

  assign res_o.acc = acc_d;
  assign res_o.neg = neg_d;
  assign res_o.err = err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLead;
      acc_q   <= '0;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
      err_q   <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q <= PhLead;
        acc_q   <= '0;
        cnt_q   <= '0;
        neg_q   <= 1'b0;
        err_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        cnt_q   <= cnt_d;
        neg_q   <= neg_d;
        err_q   <= err_d;
      end
    end
  end

endmodule
